FILE: design/periodic_action_scheduler_defines.svh
// periodic_action_scheduler_defines.svh: assertion macros for the scheduler checker
// depends on nothing; uses the clk and rst_n names of the module that expands it
`ifndef PERIODIC_ACTION_SCHEDULER_DEFINES_SVH
`define PERIODIC_ACTION_SCHEDULER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define PAS_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define PAS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: design/pas_pkg.sv
// pas_pkg: shared types and constants of the periodic action scheduler
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package pas_pkg;

    // default configuration
    localparam int MAX_ACTIONS_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 48;

    // one second of start-up margin, in microseconds
    localparam logic [31:0] US_PER_SECOND = 32'd1000000;

    // item field widths
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;

    // item modes
    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_TAKE  = 2'd2
    } pas_mode_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } pas_status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SUM,
        S_ADD_SEC,
        S_POP_RD,
        S_POP_GET,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_TAKE_SUM,
        S_INS_RD,
        S_INS_CMP,
        S_EMIT
    } pas_state_t;

endpackage

`default_nettype wire

FILE: design/periodic_action_scheduler.sv
// periodic_action_scheduler: due-time-ordered queue of periodic actions
// depends on pas_pkg
//
//  channel | signals                                  | role
//  --------+------------------------------------------+--------------------------------
//  s_      | tvalid tready tdata[87:0] tuser[1:0]     | command item in (mode in tuser)
//  m_      | tvalid tready tdata[55:0] tuser[1:0]     | result item out (status in tuser)
//
//  from accept to result register: clear, error and unknown-mode items go straight to the
//  result; add sums the due time, then walks down from the tail past entries due later;
//  take reads the head, shifts the remaining entries down, then reinserts it the same way;
//  the time per item is set by the slot memory walk
//  reset empties the queue and zeroes the start time; slot memory is not cleared
//  a result waits in the output register while the next item is accepted
`timescale 1ns / 1ps
`default_nettype none

module periodic_action_scheduler #(
    parameter int MAX_ACTIONS = pas_pkg::MAX_ACTIONS_DEF,
    parameter int TIME_WIDTH  = pas_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // fields from bit 0: now_us[47:0], action_id[7:0], interval_us[31:0]
    input  wire logic [pas_pkg::IN_DATA_W-1:0] s_tdata,
    // fields from bit 0: mode[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // fields from bit 0: due_action[7:0], due_time_us[47:0]
    output logic [pas_pkg::OUT_DATA_W-1:0]     m_tdata,
    // fields from bit 0: status[1:0]
    output logic [1:0]                         m_tuser
);
    import pas_pkg::*;

    localparam int AW   = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int CW   = $clog2(MAX_ACTIONS + 1);
    localparam int P_LO = TIME_WIDTH;
    localparam int A_LO = TIME_WIDTH + 32;
    localparam int EW   = TIME_WIDTH + 40;

    // control and working registers
    pas_state_t             state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [TIME_WIDTH-1:0]  start_reg, start_next;
    logic [TIME_WIDTH-1:0]  due_reg, due_next;
    logic [31:0]            period_reg, period_next;
    logic [7:0]             act_reg, act_next;
    pas_status_t            res_status_reg, res_status_next;
    logic [7:0]             res_act_reg, res_act_next;
    logic [47:0]            res_due_reg, res_due_next;
    logic                   out_valid_reg, out_valid_next;
    pas_status_t            out_status_reg, out_status_next;
    logic [7:0]             out_act_reg, out_act_next;
    logic [47:0]            out_due_reg, out_due_next;

    // slot memory
    logic [EW-1:0]          slot_mem [MAX_ACTIONS];
    logic [EW-1:0]          rd_data_reg;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;

    // input decode
    pas_mode_t              in_mode;
    logic [47:0]            in_now;
    logic [7:0]             in_act;
    logic [31:0]            in_period;
    logic [63:0]            now_wide;
    logic [63:0]            tmax_wide;
    logic [TIME_WIDTH-1:0]  now_sat;

    // shared saturating adder and compare
    logic [TIME_WIDTH-1:0]  add_a;
    logic [TIME_WIDTH-1:0]  add_b;
    logic [TIME_WIDTH:0]    add_sum;
    logic [TIME_WIDTH-1:0]  add_sat;
    logic                   ins_less;
    logic [CW-1:0]          idx_m1;
    logic                   out_free;

    assign in_mode   = pas_mode_t'(s_tuser);
    assign in_now    = s_tdata[47:0];
    assign in_act    = s_tdata[55:48];
    assign in_period = s_tdata[87:56];

    // clamp the current time into the time range
    assign now_wide  = 64'(in_now);
    assign tmax_wide = 64'({TIME_WIDTH{1'b1}});
    assign now_sat   = (now_wide > tmax_wide) ? {TIME_WIDTH{1'b1}}
                                              : now_wide[TIME_WIDTH-1:0];

    // adder operand select
    always_comb
    begin
        case (state_reg)
            S_ADD_SUM:
            begin
                add_a = start_reg;
                add_b = TIME_WIDTH'(period_reg);
            end
            S_ADD_SEC:
            begin
                add_a = due_reg;
                add_b = TIME_WIDTH'(US_PER_SECOND);
            end
            S_TAKE_SUM:
            begin
                add_a = due_reg;
                add_b = TIME_WIDTH'(period_reg);
            end
            default:
            begin
                add_a = due_reg;
                add_b = '0;
            end
        endcase
    end

    assign add_sum  = {1'b0, add_a} + {1'b0, add_b};
    assign add_sat  = add_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : add_sum[TIME_WIDTH-1:0];
    assign ins_less = due_reg < rd_data_reg[TIME_WIDTH-1:0];
    assign idx_m1   = idx_reg - CW'(1);
    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_mode)
                        MODE_ADD:
                            state_next = (cnt_reg >= CW'(MAX_ACTIONS)) ? S_EMIT : S_ADD_SUM;
                        MODE_TAKE:
                            state_next = (cnt_reg == '0) ? S_EMIT : S_POP_RD;
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            end
            S_ADD_SUM:  state_next = S_ADD_SEC;
            S_ADD_SEC:  state_next = S_INS_RD;
            S_POP_RD:   state_next = S_POP_GET;
            S_POP_GET:  state_next = S_SHIFT_RD;
            S_SHIFT_RD: state_next = (idx_reg < cnt_reg) ? S_SHIFT_WR : S_TAKE_SUM;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_TAKE_SUM: state_next = S_INS_RD;
            S_INS_RD:   state_next = (idx_reg == '0) ? S_EMIT : S_INS_CMP;
            S_INS_CMP:  state_next = ins_less ? S_INS_RD : S_EMIT;
            S_EMIT:     state_next = out_free ? S_IDLE : S_EMIT;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        start_next      = start_reg;
        due_next        = due_reg;
        period_next     = period_reg;
        act_next        = act_reg;
        res_status_next = res_status_reg;
        res_act_next    = res_act_reg;
        res_due_next    = res_due_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_act_next    = out_act_reg;
        out_due_next    = out_due_reg;
        rd_addr         = idx_reg[AW-1:0];
        mem_we          = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = {act_reg, period_reg, due_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_status_next = STAT_OK;
                    res_act_next    = '0;
                    res_due_next    = '0;
                    period_next     = in_period;
                    act_next        = in_act;
                    case (in_mode)
                        MODE_CLEAR:
                        begin
                            cnt_next   = '0;
                            start_next = now_sat;
                        end
                        MODE_ADD:
                        begin
                            if (cnt_reg >= CW'(MAX_ACTIONS))
                                res_status_next = STAT_FULL;
                        end
                        MODE_TAKE:
                        begin
                            if (cnt_reg == '0)
                                res_status_next = STAT_EMPTY;
                        end
                        default:
                        begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            // first due time: start + period, then one second of margin
            S_ADD_SUM:
            begin
                due_next = add_sat;
            end
            S_ADD_SEC:
            begin
                due_next = add_sat;
                idx_next = cnt_reg;
            end
            // read the head entry
            S_POP_RD:
            begin
                rd_addr = '0;
            end
            S_POP_GET:
            begin
                due_next    = rd_data_reg[TIME_WIDTH-1:0];
                period_next = rd_data_reg[A_LO-1:P_LO];
                act_next    = rd_data_reg[EW-1:A_LO];
                idx_next    = CW'(1);
            end
            // move the remaining entries down by one
            S_SHIFT_RD:
            begin
                if (idx_reg < cnt_reg)
                    rd_addr = idx_reg[AW-1:0];
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            S_SHIFT_WR:
            begin
                mem_we   = 1'b1;
                wr_addr  = idx_m1[AW-1:0];
                wr_data  = rd_data_reg;
                idx_next = idx_reg + CW'(1);
            end
            // report the popped entry and schedule its next due time
            S_TAKE_SUM:
            begin
                res_act_next = act_reg;
                res_due_next = 48'(due_reg);
                due_next     = add_sat;
                idx_next     = cnt_reg;
            end
            // walk down from the tail, opening a gap for the new entry
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    rd_addr = idx_m1[AW-1:0];
                end
            end
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (ins_less)
                begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_m1;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            // hand the result to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_act_next    = res_act_reg;
                    out_due_next    = res_due_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        due_reg        <= due_next;
        period_reg     <= period_next;
        act_reg        <= act_next;
        res_status_reg <= res_status_next;
        res_act_reg    <= res_act_next;
        res_due_reg    <= res_due_next;
        out_status_reg <= out_status_next;
        out_act_reg    <= out_act_next;
        out_due_reg    <= out_due_next;
    end

    // slot memory write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[wr_addr] <= wr_data;
    end

    // slot memory read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= slot_mem[rd_addr];
    end

    // ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_due_reg, out_act_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

FILE: design/pas_checker.sv
// pas_checker: port-level assertions for the periodic action scheduler, bound to the top
// depends on pas_pkg and periodic_action_scheduler_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_action_scheduler_defines.svh"

module pas_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [pas_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]                    s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [pas_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic [1:0]                    m_tuser
);
    import pas_pkg::*;

    // a stalled result holds
    `PAS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // the sequencer leaves idle on every accepted item
    `PAS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after accept")

    // only defined status codes are reported
    `PAS_ASSERT_NOW(a_status_code, m_tvalid, m_tuser == STAT_OK || m_tuser == STAT_EMPTY || m_tuser == STAT_FULL, "undefined status code")

    // error results carry no action or time
    `PAS_ASSERT_NOW(a_error_zero, m_tvalid && m_tuser != STAT_OK, m_tdata == '0, "error result has nonzero fields")

endmodule

bind periodic_action_scheduler pas_checker u_pas_checker (.*);

`default_nettype wire

FILE: bench/periodic_action_scheduler_test.sv
// periodic_action_scheduler_test: stream-level bench for the periodic action scheduler
// depends on pas_pkg and periodic_action_scheduler; predicts every result with its own
// copy of the due-ordered queue and compares each result item field by field
`timescale 1ns / 1ps

module periodic_action_scheduler_test;

    import pas_pkg::*;

    localparam int          QUEUE_DEPTH = MAX_ACTIONS_DEF;
    localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int          RANDOM_ITEMS = 1050;
    localparam int          HOLD_AT      = 400;
    localparam int          HOLD_CYCLES  = 300;

    typedef struct {
        logic [1:0]  mode;
        logic [47:0] now_us;
        logic [7:0]  action_id;
        logic [31:0] interval_us;
        int          gap;
    } cmd_item_t;

    typedef struct {
        pas_status_t status;
        logic [7:0]  due_action;
        logic [47:0] due_time_us;
    } due_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    wire logic             s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    wire logic             m_tvalid;
    logic                  m_tready = 1'b0;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire [1:0]             m_tuser;

    // command backlog and the results predicted for accepted items
    cmd_item_t   cmd_backlog[$];
    due_result_t pending_results[$];
    cmd_item_t   cur_item;
    due_result_t want;

    // predicted queue state, slot 0 earliest
    logic [47:0] q_due[QUEUE_DEPTH];
    logic [31:0] q_period[QUEUE_DEPTH];
    logic [7:0]  q_action[QUEUE_DEPTH];
    int          q_count = 0;
    logic [47:0] q_start = '0;

    int n_built = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int err_count = 0;
    int gap_cnt = 0;
    int stall_left = 0;
    int next_stall = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit stim_done = 1'b0;

    periodic_action_scheduler u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // saturating time sum
    function automatic logic [47:0] time_sum(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? TIME_MAX : s[47:0];
    endfunction

    // sorted insert, new entry goes behind every entry due no later
    function automatic void queue_insert(logic [47:0] due, logic [31:0] period,
                                         logic [7:0] act);
        int pos;
        int i;
        pos = 0;
        while (pos < q_count && !(due < q_due[pos]))
            pos++;
        if (q_count >= QUEUE_DEPTH)
            return;
        for (i = q_count; i > pos; i--)
        begin
            q_due[i]    = q_due[i-1];
            q_period[i] = q_period[i-1];
            q_action[i] = q_action[i-1];
        end
        q_due[pos]    = due;
        q_period[pos] = period;
        q_action[pos] = act;
        q_count++;
    endfunction

    // advance the predicted scheduler by one command item
    function automatic due_result_t scheduler_step(cmd_item_t it);
        due_result_t r;
        logic [47:0] due;
        logic [31:0] period;
        logic [7:0]  act;
        int          i;
        r.status      = STAT_OK;
        r.due_action  = '0;
        r.due_time_us = '0;
        if (it.mode == MODE_CLEAR)
        begin
            q_count = 0;
            q_start = it.now_us;
        end
        else if (it.mode == MODE_ADD)
        begin
            if (q_count >= QUEUE_DEPTH)
                r.status = STAT_FULL;
            else
                queue_insert(time_sum(time_sum(q_start, {16'd0, it.interval_us}),
                                      {16'd0, US_PER_SECOND}),
                             it.interval_us, it.action_id);
        end
        else if (it.mode == MODE_TAKE)
        begin
            if (q_count == 0)
                r.status = STAT_EMPTY;
            else
            begin
                due    = q_due[0];
                period = q_period[0];
                act    = q_action[0];
                for (i = 1; i < q_count; i++)
                begin
                    q_due[i-1]    = q_due[i];
                    q_period[i-1] = q_period[i];
                    q_action[i-1] = q_action[i];
                end
                q_count--;
                r.due_action  = act;
                r.due_time_us = due;
                queue_insert(time_sum(due, {16'd0, period}), period, act);
            end
        end
        return r;
    endfunction

    // periods: full range, millisecond steps, or tiny values that collide
    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            3:       return $urandom_range(0, 15);
            default: return 32'd1000 * $urandom_range(1, 1000);
        endcase
    endfunction

    // start times: full range, close to saturation, or small
    function automatic logic [47:0] pick_now();
        case ($urandom_range(0, 3))
            0:       return 48'({$urandom, $urandom});
            1:       return TIME_MAX - $urandom;
            default: return {16'd0, $urandom};
        endcase
    endfunction

    // queue one command item, with stretches where the sender never idles
    task automatic push_cmd(logic [1:0] mode, logic [47:0] now_us, logic [7:0] act,
                            logic [31:0] period);
        cmd_item_t it;
        it.mode        = mode;
        it.now_us      = now_us;
        it.action_id   = act;
        it.interval_us = period;
        it.gap         = ((n_built / 80) % 5 == 4) ? 0 : $urandom_range(0, 9);
        cmd_backlog.push_back(it);
        n_built++;
    endtask

    // stimulus and reset
    initial
    begin
        int n_add;
        int n_take;
        int k;
        // directed: empty take, unused mode, saturation, ties, full queue
        push_cmd(MODE_TAKE, 48'({$urandom, $urandom}), 8'($urandom), $urandom);
        push_cmd(MODE_UNUSED, TIME_MAX, 8'hFF, 32'hFFFF_FFFF);
        push_cmd(MODE_CLEAR, TIME_MAX, 8'h00, 32'h0);
        push_cmd(MODE_ADD, 48'd0, 8'h00, 32'h0000_0000);
        push_cmd(MODE_ADD, TIME_MAX, 8'hFF, 32'hFFFF_FFFF);
        for (k = 0; k < 14; k++)
            push_cmd(MODE_ADD, 48'({$urandom, $urandom}), 8'(k + 1),
                     (k % 2 == 0) ? 32'd0 : 32'hFFFF_FFFF);
        push_cmd(MODE_ADD, 48'd0, 8'h5A, 32'd7);
        push_cmd(MODE_TAKE, 48'd0, 8'h00, 32'd0);
        push_cmd(MODE_TAKE, TIME_MAX, 8'hFF, 32'hFFFF_FFFF);
        push_cmd(MODE_TAKE, 48'd0, 8'h00, 32'd0);
        push_cmd(MODE_CLEAR, 48'd0, 8'hFF, 32'hFFFF_FFFF);
        push_cmd(MODE_TAKE, 48'd0, 8'h00, 32'd0);
        // random: mostly clear, a run of adds, then takes; some noise
        while (n_built < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                n_add  = $urandom_range(1, 18);
                n_take = $urandom_range(0, 24);
                push_cmd(MODE_CLEAR, pick_now(), 8'($urandom), $urandom);
                repeat (n_add)
                    push_cmd(MODE_ADD, 48'({$urandom, $urandom}), 8'($urandom),
                             pick_period());
                repeat (n_take)
                begin
                    if ($urandom_range(0, 5) == 0)
                        push_cmd(MODE_ADD, 48'({$urandom, $urandom}), 8'($urandom),
                                 pick_period());
                    push_cmd(MODE_TAKE, 48'({$urandom, $urandom}), 8'($urandom), $urandom);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_cmd(2'($urandom_range(0, 3)), pick_now(), 8'($urandom),
                             pick_period());
            end
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: offers items from the backlog, predicts each one on accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            gap_cnt  = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                pending_results.push_back(scheduler_step(cur_item));
                n_accepted <= n_accepted + 1;
            end
            if (cmd_backlog.size() == 0)
            begin
                s_tvalid  <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (gap_cnt < cmd_backlog[0].gap)
            begin
                gap_cnt++;
                s_tvalid <= 1'b0;
            end
            else
            begin
                cur_item = cmd_backlog.pop_front();
                gap_cnt  = 0;
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_item.interval_us, cur_item.action_id, cur_item.now_us};
                s_tuser  <= cur_item.mode;
            end
        end
    end

    // long receiver hold-off once, so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // receiver: random stalls per item, checks each result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            next_stall = (stall_left > 0) ? stall_left - 1 : 0;
            if (m_tvalid && m_tready)
            begin
                n_checked <= n_checked + 1;
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, got status %0d action %0d due %0d",
                             $time, m_tuser, m_tdata[7:0], m_tdata[55:8]);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t status: expected %0d got %0d",
                                 $time, want.status, m_tuser);
                        err_count++;
                    end
                    if (m_tdata[7:0] !== want.due_action)
                    begin
                        $display("%0t due_action: expected %0d got %0d",
                                 $time, want.due_action, m_tdata[7:0]);
                        err_count++;
                    end
                    if (m_tdata[55:8] !== want.due_time_us)
                    begin
                        $display("%0t due_time_us: expected %0d got %0d",
                                 $time, want.due_time_us, m_tdata[55:8]);
                        err_count++;
                    end
                end
                // quiet stretches with no stalls at all
                next_stall = ((n_checked / 64) % 4 == 3) ? 0 : $urandom_range(0, 9);
            end
            stall_left = next_stall;
            m_tready   <= (next_stall == 0) && (hold_left == 0);
        end
    end

    // end of run: drain, let the block settle, then report
    initial
    begin
        @(posedge rst_n);
        while (!(stim_done && n_checked == n_accepted))
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
